/* src/rge_pkg.sv */
`timescale 1ns / 1ps

package rge_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned FMT_W   = 2;

  localparam logic [WORD_W-1:0] CHECK_SEED    = 32'hAB32_5F12;
  localparam logic [WORD_W-1:0] CHECK_POLY    = 32'hEDB8_8320;
  localparam logic [BYTE_W-1:0] RUN_LIMIT     = 8'd255;
  localparam logic [BYTE_W-1:0] TWO_BYTE_MASK = 8'hFC;
  localparam int unsigned       CHECK_ROUNDS  = 7;

  // pixel_format codes; code 3 behaves like the one-byte format
  localparam logic [FMT_W-1:0] FMT_ONE_BYTE  = 2'd0;
  localparam logic [FMT_W-1:0] FMT_TWO_BYTE  = 2'd1;
  localparam logic [FMT_W-1:0] FMT_FOUR_BYTE = 2'd2;

  localparam logic KIND_PAIR  = 1'b0;
  localparam logic KIND_CHECK = 1'b1;

  // result queue: holds the up to three results of one pixel plus one in flight
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_AW    = $clog2(Q_DEPTH);
  localparam int unsigned Q_CW    = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [WORD_W-1:0] pixel_word;
    logic              last_pixel;
  } pix_in_t;

  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] run_length;
    logic [BYTE_W-1:0] grey_value;
    logic [WORD_W-1:0] check_value;
    logic              end_of_image;
  } rle_res_t;

  // XOR in the sign-extended byte, then seven arithmetic-shift rounds
  function automatic logic [WORD_W-1:0] check_update(input logic [WORD_W-1:0] c_in,
                                                     input logic [BYTE_W-1:0] grey);
    logic [WORD_W-1:0] c;
    logic              lsb;
    c = c_in ^ {{(WORD_W-BYTE_W){grey[BYTE_W-1]}}, grey};
    for (int r = 0; r < CHECK_ROUNDS; r++) begin
      lsb = c[0];
      c   = {c[WORD_W-1], c[WORD_W-1:1]};
      if (lsb) begin
        c = c ^ CHECK_POLY;
      end
    end
    return c;
  endfunction

endpackage

/* src/rle_grey_image_encoder_unit.sv */
`timescale 1ns / 1ps

// channel | direction | handshake            | payload
// in_     | input     | in_valid / in_ready   | in_data  (pix_in_t)
// out_    | output    | out_valid / out_ready | out_data (rle_res_t)
// cfg_    | input     | cfg_valid / cfg_ready | cfg_data (pixel_format)
//
// One pixel per cycle while in_ready is high; a pixel is processed in the cycle
// it is accepted and its results (0 to 3) enter a four-entry result queue; the
// first is visible the next cycle. Results drain one per cycle while out_ready
// is high, so a last pixel (up to three results) holds in_ready low until the
// queue has room again. Synchronous active-low reset clears run state, format
// and queue and loads CHECK_SEED into the check word. cfg_ready is always high.
module rle_grey_image_encoder_unit (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  rge_pkg::pix_in_t        in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output rge_pkg::rle_res_t       out_data,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [rge_pkg::FMT_W-1:0] cfg_data
);
  import rge_pkg::*;

  logic [FMT_W-1:0]  fmt_r;
  logic [BYTE_W-1:0] prev_r, prev_nxt;
  logic [BYTE_W-1:0] run_r, run_nxt;
  logic [WORD_W-1:0] chk_r, chk_nxt;

  rle_res_t          q_mem [Q_DEPTH];
  logic [Q_AW-1:0]   wp_r, wp_nxt;
  logic [Q_AW-1:0]   rp_r, rp_nxt;
  logic [Q_CW-1:0]   cnt_r, cnt_nxt;

  logic              in_fire, out_fire;
  logic [BYTE_W-1:0] grey;
  logic              same;
  logic              emit_pair;
  logic [BYTE_W-1:0] prev_a, run_a;
  logic [WORD_W-1:0] chk_a;
  rle_res_t          res_pair, res_final, res_check;
  logic [Q_AW-1:0]   wp_fin, wp_chk;
  logic [Q_CW-1:0]   n_push;

  assign cfg_ready = 1'b1;
  // room for a full three-result burst
  assign in_ready  = (cnt_r <= Q_CW'(Q_DEPTH - 3));
  assign in_fire   = in_valid && in_ready;
  assign out_valid = (cnt_r != '0);
  assign out_fire  = out_valid && out_ready;
  assign out_data  = q_mem[rp_r];

  always_comb begin
    grey = in_data.pixel_word[BYTE_W-1:0];
    if (fmt_r == FMT_TWO_BYTE) begin
      grey = grey & TWO_BYTE_MASK;
    end
    same = (grey == prev_r);
    if (same) begin
      emit_pair = (run_r == RUN_LIMIT);
      prev_a    = prev_r;
      run_a     = emit_pair ? BYTE_W'(1) : run_r + BYTE_W'(1);
    end else begin
      emit_pair = (run_r != '0);
      prev_a    = grey;
      run_a     = BYTE_W'(1);
    end
    chk_a = check_update(chk_r, grey);

    res_pair  = '{kind: KIND_PAIR, run_length: run_r, grey_value: prev_r,
                  check_value: '0, end_of_image: 1'b0};
    res_final = '{kind: KIND_PAIR, run_length: run_a, grey_value: prev_a,
                  check_value: '0, end_of_image: 1'b0};
    res_check = '{kind: KIND_CHECK, run_length: '0, grey_value: '0,
                  check_value: chk_a, end_of_image: 1'b1};

    wp_fin = wp_r + Q_AW'(emit_pair);
    wp_chk = wp_fin + Q_AW'(1);
    n_push = Q_CW'(emit_pair) + (in_data.last_pixel ? Q_CW'(2) : Q_CW'(0));

    if (in_data.last_pixel) begin
      prev_nxt = '0;
      run_nxt  = '0;
      chk_nxt  = CHECK_SEED;
    end else begin
      prev_nxt = prev_a;
      run_nxt  = run_a;
      chk_nxt  = chk_a;
    end

    wp_nxt  = in_fire ? wp_r + Q_AW'(n_push) : wp_r;
    rp_nxt  = out_fire ? rp_r + Q_AW'(1) : rp_r;
    cnt_nxt = cnt_r + (in_fire ? n_push : Q_CW'(0)) - Q_CW'(out_fire);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r  <= FMT_ONE_BYTE;
      prev_r <= '0;
      run_r  <= '0;
      chk_r  <= CHECK_SEED;
      wp_r   <= '0;
      rp_r   <= '0;
      cnt_r  <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        fmt_r <= cfg_data;
      end
      if (in_fire) begin
        prev_r <= prev_nxt;
        run_r  <= run_nxt;
        chk_r  <= chk_nxt;
      end
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // queue storage, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (emit_pair) begin
        q_mem[wp_r] <= res_pair;
      end
      if (in_data.last_pixel) begin
        q_mem[wp_fin] <= res_final;
        q_mem[wp_chk] <= res_check;
      end
    end
  end

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;
  import rge_pkg::*;

  localparam int GAP_MAX = 17;
  localparam int SETTLE = 4;
  localparam int TAIL = 20;
  localparam int PHASE_PIXELS = 8;
  localparam logic [FMT_W-1:0] FMT_SPARE = 2'd3;

  // Expected-result ledger: mirrors run tracking and check-word folding of the encoder
  class image_run_ledger;
    logic [FMT_W-1:0]  fmt;
    logic [BYTE_W-1:0] last_grey;
    logic [BYTE_W-1:0] run_len;
    logic [WORD_W-1:0] check_acc;
    rle_res_t          due[$];
    int                errors;

    function new();
      fmt = FMT_ONE_BYTE;
      errors = 0;
      clear();
    endfunction

    function void clear();
      last_grey = '0;
      run_len = '0;
      check_acc = CHECK_SEED;
    endfunction

    function logic [WORD_W-1:0] fold_grey(logic [WORD_W-1:0] acc, logic [BYTE_W-1:0] g);
      logic [WORD_W-1:0] v;
      logic carry;
      v = acc ^ {{(WORD_W-BYTE_W){g[BYTE_W-1]}}, g};
      for (int i = 0; i < CHECK_ROUNDS; i++) begin
        carry = v[0];
        v = $signed(v) >>> 1;
        if (carry) v = v ^ CHECK_POLY;
      end
      return v;
    endfunction

    function void push_pair();
      rle_res_t r;
      r = '0;
      r.kind = KIND_PAIR;
      r.run_length = run_len;
      r.grey_value = last_grey;
      due.push_back(r);
    endfunction

    function void take_pixel(pix_in_t p);
      logic [BYTE_W-1:0] grey;
      rle_res_t r;
      grey = p.pixel_word[BYTE_W-1:0];
      if (fmt == FMT_TWO_BYTE) grey = grey & TWO_BYTE_MASK;
      if (grey == last_grey) begin
        // a saturated run is flushed and a fresh one begins with this pixel
        if (run_len == RUN_LIMIT) begin
          push_pair();
          run_len = '0;
        end
        run_len = run_len + 1'b1;
      end else begin
        if (run_len != 0) push_pair();
        last_grey = grey;
        run_len = BYTE_W'(1);
      end
      check_acc = fold_grey(check_acc, grey);
      if (p.last_pixel) begin
        push_pair();
        r = '0;
        r.kind = KIND_CHECK;
        r.check_value = check_acc;
        r.end_of_image = 1'b1;
        due.push_back(r);
        clear();
      end
    endfunction

    function void cmp(string name, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0h, actual %0h", name, want, got);
        errors++;
      end
    endfunction

    function void match_result(rle_res_t got);
      rle_res_t want;
      if (due.size() == 0) begin
        $error("result transaction with nothing expected: %0h", got);
        errors++;
        return;
      end
      want = due.pop_front();
      cmp("kind", WORD_W'(want.kind), WORD_W'(got.kind));
      cmp("run_length", WORD_W'(want.run_length), WORD_W'(got.run_length));
      cmp("grey_value", WORD_W'(want.grey_value), WORD_W'(got.grey_value));
      cmp("check_value", want.check_value, got.check_value);
      cmp("end_of_image", WORD_W'(want.end_of_image), WORD_W'(got.end_of_image));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  pix_in_t in_data;
  logic out_valid;
  logic out_ready;
  rle_res_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [FMT_W-1:0] cfg_data;

  image_run_ledger ledger;
  logic [FMT_W-1:0] cur_fmt;
  bit in_calm;
  bit out_calm;
  int pixels_sent;

  rle_grey_image_encoder_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // stretches of back-to-back traffic alternate with random stalls
  function automatic int draw_gap(inout bit calm);
    if ($urandom_range(0, 15) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, GAP_MAX);
  endfunction

  function automatic logic [BYTE_W-1:0] pick_grey(logic [BYTE_W-1:0] prev);
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7F;
      4: return prev + 1'b1;
      5: return prev ^ 8'h01;
      default: return BYTE_W'($urandom_range(0, 255));
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) ledger.fmt = cfg_data;
      if (in_valid && in_ready) ledger.take_pixel(in_data);
      if (out_valid && out_ready) ledger.match_result(out_data);
    end
  end

  // result sink with random back-pressure
  initial begin
    int hold;
    wait (rst_n === 1'b1);
    forever begin
      hold = draw_gap(out_calm);
      @(negedge clk);
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_pixel(pix_in_t p);
    int gap;
    gap = draw_gap(in_calm);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= p;
    do @(posedge clk); while (!in_ready);
    pixels_sent++;
  endtask

  task automatic send_run(logic [BYTE_W-1:0] grey, int len, bit close_image);
    logic [WORD_W-1:0] w;
    for (int i = 0; i < len; i++) begin
      w = $urandom;
      w[BYTE_W-1:0] = grey;
      // low bits are masked off in the two-byte format, so vary them freely
      if (cur_fmt == FMT_TWO_BYTE) w[1:0] = 2'($urandom_range(0, 3));
      send_pixel({w, close_image && (i == len - 1)});
    end
  endtask

  task automatic send_image();
    int nruns;
    int len;
    logic [BYTE_W-1:0] g;
    g = BYTE_W'($urandom_range(0, 255));
    nruns = $urandom_range(1, 8);
    for (int r = 0; r < nruns; r++) begin
      g = pick_grey(g);
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 20) : $urandom_range(1, 4);
      send_run(g, len, r == nruns - 1);
    end
  endtask

  // quiet the input and let every outstanding result drain
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (ledger.due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_format(logic [FMT_W-1:0] f);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= f;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cur_fmt = f;
  endtask

  initial begin
    logic [FMT_W-1:0] plan [4];
    plan = '{FMT_TWO_BYTE, FMT_SPARE, FMT_FOUR_BYTE, FMT_ONE_BYTE};
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    cur_fmt = FMT_ONE_BYTE;
    pixels_sent = 0;
    ledger = new();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset format: a zero first byte opens a run, sign extension of the top bit
    send_pixel({32'hFFFF_FF00, 1'b0});
    send_pixel({32'h0000_0100, 1'b0});
    send_pixel({32'h1234_5680, 1'b0});
    send_pixel({32'h0000_007F, 1'b0});
    send_pixel({32'hAAAA_AAFF, 1'b1});
    // single-pixel images, nonzero and zero first byte
    send_pixel({32'h5555_5555, 1'b1});
    send_pixel({32'h0000_0000, 1'b1});

    write_format(FMT_TWO_BYTE);
    send_pixel({32'h0000_0003, 1'b0});
    send_pixel({32'hFFFF_FF01, 1'b0});
    send_pixel({32'h0000_00FD, 1'b0});
    send_pixel({32'h0000_00FF, 1'b0});
    send_pixel({32'h0000_0080, 1'b1});

    // unused code decodes like the one-byte format
    write_format(FMT_SPARE);
    send_pixel({32'h0000_0001, 1'b0});
    send_pixel({32'h0000_0003, 1'b1});

    write_format(FMT_FOUR_BYTE);
    send_pixel({32'hFFFF_FFFE, 1'b0});
    send_pixel({32'h0000_00FE, 1'b1});

    // one pixel past a full run closes the image
    send_run(8'hC3, 256, 1'b1);

    foreach (plan[k]) begin
      write_format(plan[k]);
      pixels_sent = 0;
      while (pixels_sent < PHASE_PIXELS) send_image();
    end

    drain();
    repeat (TAIL) @(posedge clk);
    if (ledger.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
